[rtl/assert_macros.svh]
// Assertion macros for the stop-and-wait receiver RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high
`define SAWR_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Clocked check that also holds during reset
`define SAWR_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

[rtl/sawr_pkg.sv]
// Shared types, codes and checksum functions for the stop-and-wait receiver.
// No dependencies; used by the cfg, input stage, core, output stage and top files.
`default_nettype none

package sawr_pkg;

  localparam int BYTE_COUNT_WIDTH_DEF = 32;

  localparam logic [7:0] FLG_DATA    = 8'h00;
  localparam logic [7:0] FLG_SYN     = 8'h01;
  localparam logic [7:0] FLG_ACK     = 8'h02;
  localparam logic [7:0] FLG_ACK_SYN = 8'h03;
  localparam logic [7:0] FLG_FIN     = 8'h04;
  localparam logic [7:0] FLG_FIN_ACK = 8'h05;
  localparam logic [7:0] FLG_END     = 8'h07;

  localparam logic [15:0] WAIT_TICKS_RST     = 16'd500;
  localparam logic [2:0]  TRANSFER_COUNT_RST = 3'd2;
  localparam logic [2:0]  TRANSFERS_MAX      = 3'd7;
  localparam int          APB_ADDR_WIDTH     = 3;

  typedef enum logic [0:0] {
    REG_WAIT_TICKS     = 1'b0,
    REG_TRANSFER_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_SYN    = 3'd0,
    PH_ACKSYN = 3'd1,
    PH_RECV   = 3'd2,
    PH_FIN    = 3'd3,
    PH_FINACK = 3'd4,
    PH_CLOSED = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [15:0] wait_ticks;
    logic [2:0]  transfer_count;
  } sawr_cfg_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] rx_sum;
    logic [15:0] rx_datasize;
    logic [7:0]  rx_flag;
    logic [7:0]  rx_seq;
  } sawr_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_flag;
    logic [7:0]  send_seq;
    logic [15:0] send_datasize;
    logic [15:0] send_sum;
  } sawr_reply_t;

  typedef struct packed {
    sawr_reply_t reply;
    logic        payload_accept;
    logic        transfer_end;
    logic [2:0]  phase;
    logic [31:0] bytes_received;
  } sawr_result_t;

  function automatic logic [15:0] ones_fold(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[16] ? (t[15:0] + 16'd1) : t[15:0];
  endfunction

  function automatic logic [15:0] hdr_sum(input logic [15:0] sum, input logic [15:0] ds,
                                          input logic [7:0] flag, input logic [7:0] seq);
    logic [15:0] s;
    s = ones_fold(16'h0000, sum);
    s = ones_fold(s, ds);
    s = ones_fold(s, {seq, flag});
    return ~s;
  endfunction

  function automatic sawr_reply_t make_reply(input logic [7:0] flag, input logic [7:0] seq,
                                             input logic [15:0] ds);
    sawr_reply_t r;
    r.send_valid    = 1'b1;
    r.send_flag     = flag;
    r.send_seq      = seq;
    r.send_datasize = ds;
    r.send_sum      = hdr_sum(16'h0000, ds, flag, seq);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sawr_ifs.sv]
// Valid/ready channel interfaces for received headers and reply results.
// No dependencies beyond the language; used by the stages and the top level.
`default_nettype none

interface sawr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] rx_sum;
  logic [15:0] rx_datasize;
  logic [7:0]  rx_flag;
  logic [7:0]  rx_seq;

  modport source(output valid, mode, rx_sum, rx_datasize, rx_flag, rx_seq, input ready);
  modport sink(input valid, mode, rx_sum, rx_datasize, rx_flag, rx_seq, output ready);
endinterface

interface sawr_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_flag;
  logic [7:0]  send_seq;
  logic [15:0] send_datasize;
  logic [15:0] send_sum;
  logic        payload_accept;
  logic        transfer_end;
  logic [2:0]  phase;
  logic [31:0] bytes_received;

  modport source(output valid, send_valid, send_flag, send_seq, send_datasize, send_sum,
                 payload_accept, transfer_end, phase, bytes_received, input ready);
  modport sink(input valid, send_valid, send_flag, send_seq, send_datasize, send_sum,
               payload_accept, transfer_end, phase, bytes_received, output ready);
endinterface

`default_nettype wire

[rtl/sawr_cfg.sv]
// APB-style register port holding wait_ticks and transfer_count.
// Depends on sawr_pkg.
`default_nettype none

module sawr_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sawr_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  wire logic [31:0]                          pwdata,
  output logic      [31:0]                          prdata,
  output logic                                      pready,
  output sawr_pkg::sawr_cfg_t                       cfg
);

  sawr_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = sawr_pkg::reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_ticks     <= sawr_pkg::WAIT_TICKS_RST;
      cfg.transfer_count <= sawr_pkg::TRANSFER_COUNT_RST;
    end else if (wr) begin
      unique case (idx)
        sawr_pkg::REG_WAIT_TICKS:     cfg.wait_ticks     <= pwdata[15:0];
        sawr_pkg::REG_TRANSFER_COUNT: cfg.transfer_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sawr_pkg::REG_WAIT_TICKS:     prdata = {16'h0000, cfg.wait_ticks};
      sawr_pkg::REG_TRANSFER_COUNT: prdata = {29'h0, cfg.transfer_count};
      default:                      prdata = 32'h0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/sawr_in_stage.sv]
// Input register: captures one header or tick transaction per cycle while it has room.
// Depends on sawr_pkg and sawr_in_if.
`default_nettype none

module sawr_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  sawr_in_if.sink              in_ch,
  input  wire logic            take,
  output logic                 item_valid,
  output sawr_pkg::sawr_item_t item
);

  assign in_ch.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.mode        <= in_ch.mode;
      item.rx_sum      <= in_ch.rx_sum;
      item.rx_datasize <= in_ch.rx_datasize;
      item.rx_flag     <= in_ch.rx_flag;
      item.rx_seq      <= in_ch.rx_seq;
    end
  end

endmodule

`default_nettype wire

[rtl/sawr_core.sv]
// Link state and per-item reply logic: handshake phases, sequence check,
// byte count and resend timer. Depends on sawr_pkg.
`default_nettype none

module sawr_core #(
  parameter int BYTE_COUNT_WIDTH = sawr_pkg::BYTE_COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sawr_pkg::sawr_cfg_t  cfg,
  input  wire sawr_pkg::sawr_item_t item,
  input  wire logic              advance,
  output sawr_pkg::sawr_result_t res,
  output sawr_pkg::phase_t       phase
);

  localparam int WIDE = BYTE_COUNT_WIDTH + 32;

  sawr_pkg::phase_t              phase_next;
  logic [7:0]                    expected_seq, expected_seq_next;
  logic [2:0]                    transfers_done, transfers_done_next;
  logic [15:0]                   wait_timer, wait_timer_next;
  logic [15:0]                   echo_datasize, echo_datasize_next;
  logic [7:0]                    echo_seq, echo_seq_next;
  logic [BYTE_COUNT_WIDTH-1:0]   byte_total, byte_total_next, shown;
  logic [BYTE_COUNT_WIDTH:0]     byte_sum;
  logic [WIDE-1:0]               shown_wide;
  logic [16:0]                   tick_count;
  logic                          good;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sawr_pkg::PH_SYN;
      expected_seq   <= '0;
      transfers_done <= '0;
      wait_timer     <= '0;
      echo_datasize  <= '0;
      echo_seq       <= '0;
      byte_total     <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      expected_seq   <= expected_seq_next;
      transfers_done <= transfers_done_next;
      wait_timer     <= wait_timer_next;
      echo_datasize  <= echo_datasize_next;
      echo_seq       <= echo_seq_next;
      byte_total     <= byte_total_next;
    end
  end

  assign good = sawr_pkg::hdr_sum(item.rx_sum, item.rx_datasize, item.rx_flag,
                                  item.rx_seq) == 16'h0000;
  assign tick_count = {1'b0, wait_timer} + 17'd1;
  assign byte_sum   = {1'b0, byte_total} + (BYTE_COUNT_WIDTH + 1)'(item.rx_datasize);

  always_comb begin
    phase_next          = phase;
    expected_seq_next   = expected_seq;
    transfers_done_next = transfers_done;
    wait_timer_next     = wait_timer;
    echo_datasize_next  = echo_datasize;
    echo_seq_next       = echo_seq;
    byte_total_next     = byte_total;
    res                 = '0;
    shown               = byte_total;

    if (item.mode) begin
      if (phase == sawr_pkg::PH_ACKSYN || phase == sawr_pkg::PH_FINACK) begin
        if (tick_count > {1'b0, cfg.wait_ticks}) begin
          wait_timer_next = '0;
          res.reply = sawr_pkg::make_reply(sawr_pkg::FLG_ACK, echo_seq, echo_datasize);
        end else begin
          wait_timer_next = tick_count[15:0];
        end
      end
    end else begin
      unique case (phase)
        sawr_pkg::PH_SYN, sawr_pkg::PH_FIN: begin
          if (good && item.rx_flag == ((phase == sawr_pkg::PH_SYN) ? sawr_pkg::FLG_SYN
                                                                 : sawr_pkg::FLG_FIN)) begin
            echo_datasize_next = item.rx_datasize;
            echo_seq_next      = item.rx_seq;
            wait_timer_next    = '0;
            res.reply = sawr_pkg::make_reply(sawr_pkg::FLG_ACK, item.rx_seq,
                                             item.rx_datasize);
            phase_next = (phase == sawr_pkg::PH_SYN) ? sawr_pkg::PH_ACKSYN
                                                     : sawr_pkg::PH_FINACK;
          end
        end
        sawr_pkg::PH_ACKSYN: begin
          phase_next = (good && item.rx_flag == sawr_pkg::FLG_ACK_SYN) ? sawr_pkg::PH_RECV
                                                                       : sawr_pkg::PH_ERROR;
        end
        sawr_pkg::PH_FINACK: begin
          if (good && item.rx_flag == sawr_pkg::FLG_FIN_ACK) begin
            res.reply = sawr_pkg::make_reply(sawr_pkg::FLG_FIN_ACK, echo_seq, echo_datasize);
            phase_next = sawr_pkg::PH_CLOSED;
          end else begin
            phase_next = sawr_pkg::PH_ERROR;
          end
        end
        sawr_pkg::PH_RECV: begin
          if (item.rx_flag == sawr_pkg::FLG_DATA) begin
            if (item.rx_seq == expected_seq) begin
              byte_total_next = byte_sum[BYTE_COUNT_WIDTH] ? '1
                                                           : byte_sum[BYTE_COUNT_WIDTH-1:0];
              shown              = byte_total_next;
              res.payload_accept = 1'b1;
              res.reply = sawr_pkg::make_reply(sawr_pkg::FLG_ACK, expected_seq, 16'h0000);
              expected_seq_next  = expected_seq + 8'd1;
            end else begin
              res.reply = sawr_pkg::make_reply(sawr_pkg::FLG_ACK, expected_seq - 8'd1,
                                               16'h0000);
            end
          end else if (item.rx_flag == sawr_pkg::FLG_END && good) begin
            res.reply = sawr_pkg::make_reply(sawr_pkg::FLG_END, item.rx_seq,
                                             item.rx_datasize);
            res.transfer_end    = 1'b1;
            expected_seq_next   = '0;
            transfers_done_next = (transfers_done < sawr_pkg::TRANSFERS_MAX) ?
                                  transfers_done + 3'd1 : transfers_done;
            if (transfers_done_next >= cfg.transfer_count) begin
              phase_next = sawr_pkg::PH_FIN;
            end
            byte_total_next = '0;
          end
        end
        default: ;
      endcase
    end

    shown_wide         = WIDE'(shown);
    res.phase          = phase_next;
    res.bytes_received = shown_wide[31:0];
  end

endmodule

`default_nettype wire

[rtl/sawr_out_stage.sv]
// Result register: holds one reply transaction until the sink takes it.
// Depends on sawr_pkg and sawr_out_if.
`default_nettype none

module sawr_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire sawr_pkg::sawr_result_t res,
  output logic                   room,
  sawr_out_if.source             out_ch
);

  sawr_pkg::sawr_result_t res_q;
  logic                   res_valid;

  assign room = !res_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (room) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      res_q <= res;
    end
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.send_valid     = res_q.reply.send_valid;
  assign out_ch.send_flag      = res_q.reply.send_flag;
  assign out_ch.send_seq       = res_q.reply.send_seq;
  assign out_ch.send_datasize  = res_q.reply.send_datasize;
  assign out_ch.send_sum       = res_q.reply.send_sum;
  assign out_ch.payload_accept = res_q.payload_accept;
  assign out_ch.transfer_end   = res_q.transfer_end;
  assign out_ch.phase          = res_q.phase;
  assign out_ch.bytes_received = res_q.bytes_received;

endmodule

`default_nettype wire

[rtl/stop_and_wait_receiver_top.sv]
// Flow: a header or tick is captured in the input register, and its result from the
// state/reply logic is loaded into the result register, which holds it for the sink.
// Throughput: one transaction per cycle while the result register has room; input
// register, state/reply logic and result register each take one item per cycle.
// Reset (rst, synchronous): phase SYN, counters, timer and byte total cleared,
// wait_ticks 500 and transfer_count 2. Depends on sawr_pkg, sawr_ifs, sub-modules.
`default_nettype none
`include "assert_macros.svh"

module stop_and_wait_receiver_top #(
  parameter int BYTE_COUNT_WIDTH = sawr_pkg::BYTE_COUNT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  sawr_in_if.sink                                  in_ch,
  sawr_out_if.source                               out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [sawr_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);

  sawr_pkg::sawr_cfg_t    cfg;
  sawr_pkg::sawr_item_t   item;
  sawr_pkg::sawr_result_t res;
  sawr_pkg::phase_t       core_phase;
  logic                   item_valid;
  logic                   room;
  logic                   take;

  assign take = item_valid && room;

  sawr_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  sawr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .take      (take),
    .item_valid(item_valid),
    .item      (item)
  );

  sawr_core #(
    .BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .advance(take),
    .res    (res),
    .phase  (core_phase)
  );

  sawr_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (take),
    .res   (res),
    .room  (room),
    .out_ch(out_ch)
  );

  `SAWR_ASSERT(a_closed_stays, clk, rst, (core_phase == sawr_pkg::PH_CLOSED) |=> (core_phase == sawr_pkg::PH_CLOSED), "closed phase left")
  `SAWR_ASSERT(a_accept_acked, clk, rst, (out_ch.valid && (out_ch.payload_accept || out_ch.transfer_end)) |-> out_ch.send_valid, "accepted data without reply")
  `SAWR_ASSERT(a_stall_holds_item, clk, rst, (item_valid && !room) |=> item_valid, "pending item dropped")
  `SAWR_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (!item_valid && !out_ch.valid), "stage valid after reset")

endmodule

`default_nettype wire
